[rtl/pgr_pkg.sv]
package pgr_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int TAP_W          = 16;
	localparam int TICK_W         = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int LIMIT_W        = 8;
	localparam int QDEPTH         = 4;

	typedef enum logic [2:0] {
		EV_CLICK = 3'd0,
		EV_FLING = 3'd1,
		EV_MOVE  = 3'd2,
		EV_UP    = 3'd3,
		EV_HOLD  = 3'd4,
		EV_DOWN  = 3'd5
	} ev_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLICK_MAX  = 2'd0,
		CFG_TAP_GAP    = 2'd1,
		CFG_FLING_TPP  = 2'd2,
		CFG_SLOW_LIMIT = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FE_IDLE,
		FE_DIST,
		FE_MUL,
		FE_EMIT1,
		FE_EMIT2
	} fe_state_t;

	localparam logic [15:0]        CLICK_MAX_RST  = 16'd200;
	localparam logic [15:0]        TAP_GAP_RST    = 16'd300;
	localparam logic [15:0]        FLING_TPP_RST  = 16'd5;
	localparam logic [LIMIT_W-1:0] SLOW_LIMIT_RST = 8'd3;

	// width of one queued event record: kind, four coordinates, taps, elapsed, last
	function automatic int cmd_bits(input int coord_bits);
		return 3 + 4 * coord_bits + TAP_W + TICK_W + 1;
	endfunction

endpackage

[rtl/pgr_sample_if.sv]
interface pgr_sample_if #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         is_pressed;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic [31:0]                  now_tick;

	modport source (output valid, is_pressed, pos_x, pos_y, now_tick, input ready);
	modport sink (input valid, is_pressed, pos_x, pos_y, now_tick, output ready);
endinterface

[rtl/pgr_event_if.sv]
interface pgr_event_if #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   event_kind;
	logic signed [COORD_BITS-1:0] from_x;
	logic signed [COORD_BITS-1:0] from_y;
	logic signed [COORD_BITS-1:0] to_x;
	logic signed [COORD_BITS-1:0] to_y;
	logic [15:0]                  tap_count;
	logic [31:0]                  elapsed_ticks;
	logic                         last_of_run;

	modport source (output valid, event_kind, from_x, from_y, to_x, to_y, tap_count,
		elapsed_ticks, last_of_run, input ready);
	modport sink (input valid, event_kind, from_x, from_y, to_x, to_y, tap_count,
		elapsed_ticks, last_of_run, output ready);
endinterface

[rtl/pgr_cfg_if.sv]
interface pgr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pgr_pkg::CFG_IDX_W-1:0]      index;
	logic [pgr_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/pgr_front.sv]
module pgr_front #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	pgr_sample_if.sink                               samp,
	pgr_cfg_if.sink                                  cfg,
	input  logic                                     q_room2,
	output logic                                     push,
	output logic [pgr_pkg::cmd_bits(COORD_BITS)-1:0] cmd
);
	import pgr_pkg::*;

	localparam int PROD_W = CFG_DATA_W + COORD_BITS;
	localparam int CMP_W  = (PROD_W > TICK_W) ? PROD_W : TICK_W;

	typedef struct packed {
		ev_kind_t                     kind;
		logic signed [COORD_BITS-1:0] from_x;
		logic signed [COORD_BITS-1:0] from_y;
		logic signed [COORD_BITS-1:0] to_x;
		logic signed [COORD_BITS-1:0] to_y;
		logic [TAP_W-1:0]             taps;
		logic [TICK_W-1:0]            elapsed;
		logic                         last;
	} cmd_t;

	fe_state_t state_q, state_n;

	// configuration
	logic [15:0]        click_max_q, tap_gap_q, fling_tpp_q;
	logic [LIMIT_W-1:0] slow_limit_q;

	// gesture state
	logic                         was_q;
	logic signed [COORD_BITS-1:0] ax_q, ay_q;
	logic [TICK_W-1:0]            mark_q;
	logic [TAP_W-1:0]             taps_q;
	logic [LIMIT_W-1:0]           slow_q;

	// captured sample
	logic                         pressed_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [TICK_W-1:0]            now_q;

	logic [COORD_BITS-1:0] dist_s1;
	logic [TICK_W-1:0]     elapsed_s1;
	logic [PROD_W-1:0]     prod_s2;
	cmd_t                  ev2_q;

	logic                  accept;
	logic [COORD_BITS:0]   dx, dy, adx, ady;
	logic [COORD_BITS-1:0] span;
	logic                  fast, nz, click, fling, slow_inc, ev1_vld, upd;
	logic [TAP_W-1:0]      taps_inc;
	cmd_t                  ev1, ev2;
	logic                  was_n;
	logic signed [COORD_BITS-1:0] ax_n, ay_n;
	logic [TICK_W-1:0]     mark_n;
	logic [TAP_W-1:0]      taps_n;
	logic [LIMIT_W-1:0]    slow_n;

	assign cfg.ready = 1'b1;
	assign accept    = samp.valid && samp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_max_q  <= CLICK_MAX_RST;
			tap_gap_q    <= TAP_GAP_RST;
			fling_tpp_q  <= FLING_TPP_RST;
			slow_limit_q <= SLOW_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_CLICK_MAX:  click_max_q  <= cfg.data;
				CFG_TAP_GAP:    tap_gap_q    <= cfg.data;
				CFG_FLING_TPP:  fling_tpp_q  <= cfg.data;
				CFG_SLOW_LIMIT: slow_limit_q <= cfg.data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// chebyshev distance from the anchor, full precision difference
	always_comb begin
		dx   = {px_q[COORD_BITS-1], px_q} - {ax_q[COORD_BITS-1], ax_q};
		dy   = {py_q[COORD_BITS-1], py_q} - {ay_q[COORD_BITS-1], ay_q};
		adx  = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
		ady  = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
		span = (adx > ady) ? adx[COORD_BITS-1:0] : ady[COORD_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pressed_q <= samp.is_pressed;
			px_q      <= samp.pos_x;
			py_q      <= samp.pos_y;
			now_q     <= samp.now_tick;
		end
		if (state_q == FE_DIST) begin
			dist_s1    <= span;
			elapsed_s1 <= now_q - mark_q;
		end
		// elapsed / dist < tpp is the same as elapsed < tpp * dist
		if (state_q == FE_MUL)
			prod_s2 <= PROD_W'(fling_tpp_q) * PROD_W'(dist_s1);
		if (state_q == FE_EMIT1)
			ev2_q <= ev2;
	end

	// decision on the captured sample against the old state
	always_comb begin
		nz       = (dist_s1 != '0);
		fast     = (CMP_W'(elapsed_s1) < CMP_W'(prod_s2));
		taps_inc = taps_q + TAP_W'(1);
		click    = (elapsed_s1 < TICK_W'(click_max_q));
		fling    = 1'b0;
		slow_inc = 1'b0;
		ev1_vld  = 1'b0;
		upd      = 1'b1;
		was_n    = was_q;
		ax_n     = ax_q;
		ay_n     = ay_q;
		mark_n   = mark_q;
		taps_n   = taps_q;
		slow_n   = slow_q;
		ev1 = '{kind: EV_MOVE, from_x: ax_q, from_y: ay_q, to_x: px_q, to_y: py_q,
			taps: taps_inc, elapsed: elapsed_s1, last: 1'b0};
		ev2 = '{kind: EV_HOLD, from_x: ax_q, from_y: ay_q, to_x: px_q, to_y: py_q,
			taps: taps_inc, elapsed: elapsed_s1, last: 1'b1};
		if (!pressed_q) begin
			if (!was_q) begin
				upd = 1'b0;
			end else begin
				fling    = !click && (slow_q < slow_limit_q) && nz && fast;
				ev1_vld  = click || fling || nz;
				ev1.kind = click ? EV_CLICK : (fling ? EV_FLING : EV_MOVE);
				ev2.kind = EV_UP;
				was_n    = 1'b0;
				taps_n   = taps_inc;
				mark_n   = now_q;
			end
		end else if (!was_q) begin
			ev2.kind = EV_DOWN;
			was_n    = 1'b1;
			ax_n     = px_q;
			ay_n     = py_q;
			slow_n   = '0;
			mark_n   = now_q;
			if (elapsed_s1 > TICK_W'(tap_gap_q))
				taps_n = '0;
		end else begin
			slow_inc = nz && !fast && (slow_q <= slow_limit_q) && (slow_q != '1);
			slow_n   = slow_q + LIMIT_W'(slow_inc);
			ev1_vld  = (slow_n >= slow_limit_q);
			if (ev1_vld) begin
				ax_n = px_q;
				ay_n = py_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_q  <= 1'b0;
			ax_q   <= '0;
			ay_q   <= '0;
			mark_q <= '0;
			taps_q <= '0;
			slow_q <= '0;
		end else if (state_q == FE_EMIT1 && upd) begin
			was_q  <= was_n;
			ax_q   <= ax_n;
			ay_q   <= ay_n;
			mark_q <= mark_n;
			taps_q <= taps_n;
			slow_q <= slow_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= FE_IDLE;
		else
			state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			FE_IDLE:  if (accept) state_n = FE_DIST;
			FE_DIST:  state_n = FE_MUL;
			FE_MUL:   state_n = FE_EMIT1;
			FE_EMIT1: state_n = upd ? FE_EMIT2 : FE_IDLE;
			FE_EMIT2: state_n = FE_IDLE;
			default:  state_n = FE_IDLE;
		endcase
	end

	always_comb begin
		samp.ready = 1'b0;
		push       = 1'b0;
		cmd        = ev1;
		unique case (state_q)
			FE_IDLE:  samp.ready = q_room2;
			FE_EMIT1: push = ev1_vld && upd;
			FE_EMIT2: begin
				push = 1'b1;
				cmd  = ev2_q;
			end
			default: ;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == FE_DIST)
		else $error("sample beat did not start the sequence");
	a_last_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FE_EMIT2 |-> push && cmd[0])
		else $error("closing event not pushed with last flag");
endmodule

[rtl/pgr_queue.sv]
module pgr_queue #(
	parameter int W     = pgr_pkg::cmd_bits(pgr_pkg::COORD_BITS_DEF),
	parameter int DEPTH = pgr_pkg::QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         room2,
	input  logic         pop,
	output logic         q_valid,
	output logic [W-1:0] rdata
);
	import pgr_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign room2   = (count_q <= CNT_W'(DEPTH - 2));
	assign q_valid = (count_q != '0);
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < CNT_W'(DEPTH))
		else $error("event queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("event queue underflow");
endmodule

[rtl/pgr_back.sv]
module pgr_back #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     q_valid,
	input  logic [pgr_pkg::cmd_bits(COORD_BITS)-1:0] q_data,
	output logic                                     pop,
	pgr_event_if.source                              gest
);
	import pgr_pkg::*;

	typedef struct packed {
		ev_kind_t                     kind;
		logic signed [COORD_BITS-1:0] from_x;
		logic signed [COORD_BITS-1:0] from_y;
		logic signed [COORD_BITS-1:0] to_x;
		logic signed [COORD_BITS-1:0] to_y;
		logic [TAP_W-1:0]             taps;
		logic [TICK_W-1:0]            elapsed;
		logic                         last;
	} cmd_t;

	cmd_t in_c, fmt, out_q;
	logic valid_q;

	assign in_c = q_data;
	assign pop  = q_valid && (!valid_q || gest.ready);

	// keep only the fields that mean something for the event kind
	always_comb begin
		fmt      = '0;
		fmt.kind = in_c.kind;
		fmt.last = in_c.last;
		unique case (in_c.kind) inside
			EV_CLICK: fmt.taps = in_c.taps;
			EV_FLING, EV_MOVE: begin
				fmt.from_x = in_c.from_x;
				fmt.from_y = in_c.from_y;
				fmt.to_x   = in_c.to_x;
				fmt.to_y   = in_c.to_y;
			end
			EV_UP: begin
				fmt.to_x = in_c.to_x;
				fmt.to_y = in_c.to_y;
				fmt.taps = in_c.taps;
			end
			EV_HOLD, EV_DOWN: fmt.elapsed = in_c.elapsed;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (gest.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= fmt;
	end

	assign gest.valid         = valid_q;
	assign gest.event_kind    = out_q.kind;
	assign gest.from_x        = out_q.from_x;
	assign gest.from_y        = out_q.from_y;
	assign gest.to_x          = out_q.to_x;
	assign gest.to_y          = out_q.to_y;
	assign gest.tap_count     = out_q.taps;
	assign gest.elapsed_ticks = out_q.elapsed;
	assign gest.last_of_run   = out_q.last;

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("popped event not presented");
endmodule

[rtl/pointer_gesture_recognizer_core.sv]
// a sample is captured, its distance and product are registered, and its events pass
// through the queue to the output register; no new sample is taken before they are
// queued, and only when the 4-entry event queue has room for two events
// arst_n clears the sequencer, queue, output valid flag and gesture state, and loads
// the configuration registers with their defaults
module pointer_gesture_recognizer_core #(
	parameter int COORD_BITS = pgr_pkg::COORD_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	pgr_sample_if.sink  samp,
	pgr_event_if.source gest,
	pgr_cfg_if.sink     cfg
);
	import pgr_pkg::*;

	localparam int CMD_W = cmd_bits(COORD_BITS);

	logic             push, room2, pop, q_valid;
	logic [CMD_W-1:0] cmd, q_data;

	pgr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samp    (samp),
		.cfg     (cfg),
		.q_room2 (room2),
		.push    (push),
		.cmd     (cmd)
	);

	pgr_queue #(.W(CMD_W), .DEPTH(QDEPTH)) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wdata   (cmd),
		.room2   (room2),
		.pop     (pop),
		.q_valid (q_valid),
		.rdata   (q_data)
	);

	pgr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.gest    (gest)
	);
endmodule

[tb/tb_pointer_gesture_recognizer_core.sv]
module tb_pointer_gesture_recognizer_core;
	import pgr_pkg::*;

	localparam int CW            = COORD_BITS_DEF;
	localparam int EVENT_LATENCY = 5;
	localparam int MAX_REPORTS   = 10;
	localparam int DRAIN_LIMIT   = 5000;

	typedef struct packed {
		ev_kind_t             kind;
		logic signed [CW-1:0] from_x;
		logic signed [CW-1:0] from_y;
		logic signed [CW-1:0] to_x;
		logic signed [CW-1:0] to_y;
		logic [TAP_W-1:0]     taps;
		logic [TICK_W-1:0]    elapsed;
		logic                 last;
	} gesture_ev_t;

	logic clk;
	logic arst_n;

	pgr_sample_if #(.COORD_BITS(CW)) samp();
	pgr_event_if #(.COORD_BITS(CW))  gest();
	pgr_cfg_if                       cfg();

	pointer_gesture_recognizer_core #(.COORD_BITS(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samp   (samp),
		.gest   (gest),
		.cfg    (cfg)
	);

	// gesture tracker copy
	logic                 held_down;
	logic signed [CW-1:0] anchor_px;
	logic signed [CW-1:0] anchor_py;
	logic [TICK_W-1:0]    press_tick;
	logic [TAP_W-1:0]     tap_run;
	logic [LIMIT_W-1:0]   slow_count;

	logic [15:0]          cfg_click_max;
	logic [15:0]          cfg_tap_gap;
	logic [15:0]          cfg_fling_tpp;
	logic [LIMIT_W-1:0]   cfg_slow_limit;

	gesture_ev_t          pending_events[$];
	int                   mismatch_count;

	// stimulus walk state
	logic signed [CW-1:0] cur_x;
	logic signed [CW-1:0] cur_y;
	logic [TICK_W-1:0]    tick_now;

	bit                   src_calm;
	bit                   sink_calm;
	int                   sink_hold;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4800000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic gesture_ev_t make_event(input ev_kind_t kind,
		input logic signed [CW-1:0] fx, input logic signed [CW-1:0] fy,
		input logic signed [CW-1:0] tx, input logic signed [CW-1:0] ty,
		input logic [TAP_W-1:0] taps, input logic [TICK_W-1:0] elapsed, input logic last);
		gesture_ev_t ev;
		ev.kind    = kind;
		ev.from_x  = fx;
		ev.from_y  = fy;
		ev.to_x    = tx;
		ev.to_y    = ty;
		ev.taps    = taps;
		ev.elapsed = elapsed;
		ev.last    = last;
		return ev;
	endfunction

	function automatic void predict_events(input logic pressed, input logic signed [CW-1:0] px,
		input logic signed [CW-1:0] py, input logic [TICK_W-1:0] now);
		logic [TICK_W-1:0] elapsed;
		longint            dx;
		longint            dy;
		longint unsigned   span;
		longint unsigned   pace;
		elapsed = now - press_tick;
		dx = longint'(anchor_px) - longint'(px);
		dy = longint'(anchor_py) - longint'(py);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		span = (dx > dy) ? dx : dy;
		// ticks per pixel, only meaningful when the pointer moved
		pace = (span != 0) ? longint'(elapsed) / span : 0;

		if (!pressed) begin
			if (!held_down)
				return;
			held_down = 1'b0;
			tap_run   = tap_run + 1'b1;
			if (elapsed < cfg_click_max)
				pending_events.push_back(make_event(EV_CLICK, '0, '0, '0, '0, tap_run, '0,
					1'b0));
			else if (slow_count < cfg_slow_limit && span != 0 && pace < cfg_fling_tpp)
				pending_events.push_back(make_event(EV_FLING, anchor_px, anchor_py, px, py,
					'0, '0, 1'b0));
			else if (span != 0)
				pending_events.push_back(make_event(EV_MOVE, anchor_px, anchor_py, px, py,
					'0, '0, 1'b0));
			press_tick = now;
			pending_events.push_back(make_event(EV_UP, '0, '0, px, py, tap_run, '0, 1'b1));
			return;
		end

		if (!held_down) begin
			held_down  = 1'b1;
			anchor_px  = px;
			anchor_py  = py;
			slow_count = '0;
			press_tick = now;
			if (elapsed > cfg_tap_gap)
				tap_run = '0;
			pending_events.push_back(make_event(EV_DOWN, '0, '0, '0, '0, '0, elapsed, 1'b1));
			return;
		end

		// slow steps count up to one past the limit, never past 255
		if (span != 0 && pace >= cfg_fling_tpp && slow_count <= cfg_slow_limit &&
				slow_count != 8'hFF)
			slow_count = slow_count + 1'b1;
		if (slow_count >= cfg_slow_limit) begin
			pending_events.push_back(make_event(EV_MOVE, anchor_px, anchor_py, px, py,
				'0, '0, 1'b0));
			anchor_px = px;
			anchor_py = py;
		end
		pending_events.push_back(make_event(EV_HOLD, '0, '0, '0, '0, '0, elapsed, 1'b1));
	endfunction

	task automatic report_mismatch(input string why, input gesture_ev_t want,
		input gesture_ev_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$write("%0t %s: expected kind %0d from (%0d,%0d) to (%0d,%0d)",
				$time, why, want.kind, want.from_x, want.from_y, want.to_x, want.to_y);
			$display(" taps %0d elapsed %0d last %0d", want.taps, want.elapsed, want.last);
			$write("%0t %s: actual   kind %0d from (%0d,%0d) to (%0d,%0d)",
				$time, why, got.kind, got.from_x, got.from_y, got.to_x, got.to_y);
			$display(" taps %0d elapsed %0d last %0d", got.taps, got.elapsed, got.last);
		end
	endtask

	always @(posedge clk) begin : event_check
		gesture_ev_t seen;
		gesture_ev_t want;
		if (arst_n && gest.valid && gest.ready) begin
			seen.kind    = ev_kind_t'(gest.event_kind);
			seen.from_x  = gest.from_x;
			seen.from_y  = gest.from_y;
			seen.to_x    = gest.to_x;
			seen.to_y    = gest.to_y;
			seen.taps    = gest.tap_count;
			seen.elapsed = gest.elapsed_ticks;
			seen.last    = gest.last_of_run;
			if (pending_events.size() == 0) begin
				report_mismatch("unexpected event", '0, seen);
			end else begin
				want = pending_events.pop_front();
				if (seen.kind !== want.kind || seen.from_x !== want.from_x ||
						seen.from_y !== want.from_y || seen.to_x !== want.to_x ||
						seen.to_y !== want.to_y || seen.taps !== want.taps ||
						seen.elapsed !== want.elapsed || seen.last !== want.last)
					report_mismatch("wrong event", want, seen);
			end
		end
	end

	// output ready: random stalls, calm stretches and long hold-offs
	initial begin
		gest.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sink_hold > 0) begin
				gest.ready <= 1'b0;
				sink_hold--;
			end else if (sink_calm) begin
				gest.ready <= 1'b1;
			end else begin
				gest.ready <= ($urandom_range(99) >= 10);
			end
		end
	end

	// valid stays high across back-to-back beats; it is lowered only for a gap or by drain_events
	task automatic send_sample(input logic pressed, input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y, input logic [TICK_W-1:0] tick);
		int gap;
		gap = 0;
		if (!src_calm && $urandom_range(99) < 10)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			samp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samp.valid      <= 1'b1;
		samp.is_pressed <= pressed;
		samp.pos_x      <= x;
		samp.pos_y      <= y;
		samp.now_tick   <= tick;
		@(posedge clk);
		while (!samp.ready) @(posedge clk);
		predict_events(pressed, x, y, tick);
	endtask

	task automatic drain_events();
		int waited;
		samp.valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_events.size() != 0 && waited < DRAIN_LIMIT);
		// a release while released leaves nothing queued but may still be in flight
		repeat (EVENT_LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_config(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			CFG_CLICK_MAX:  cfg_click_max  = value;
			CFG_TAP_GAP:    cfg_tap_gap    = value;
			CFG_FLING_TPP:  cfg_fling_tpp  = value;
			CFG_SLOW_LIMIT: cfg_slow_limit = value[LIMIT_W-1:0];
			default: ;
		endcase
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all_config(input logic [15:0] click, input logic [15:0] gap,
		input logic [15:0] tpp, input logic [15:0] limit);
		write_config(CFG_CLICK_MAX, click);
		write_config(CFG_TAP_GAP, gap);
		write_config(CFG_FLING_TPP, tpp);
		write_config(CFG_SLOW_LIMIT, limit);
	endtask

	// mostly short steps, some right on the click and tap-gap thresholds, a few wild
	function automatic logic [TICK_W-1:0] next_tick_step();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		else if (pick < 55)
			return $urandom_range(0, 400);
		else if (pick < 75)
			return $urandom_range(0, 4000);
		else if (pick < 85)
			return 32'(cfg_click_max) + $urandom_range(0, 2) - 1;
		else if (pick < 95)
			return 32'(cfg_tap_gap) + $urandom_range(0, 2) - 1;
		return $urandom;
	endfunction

	task automatic step_and_send(input logic pressed);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick >= 30 && pick < 88) begin
			cur_x = CW'(int'(cur_x) + int'($urandom_range(0, 40)) - 20);
			cur_y = CW'(int'(cur_y) + int'($urandom_range(0, 40)) - 20);
		end else if (pick >= 88) begin
			cur_x = CW'($urandom);
			cur_y = CW'($urandom);
		end
		tick_now = tick_now + next_tick_step();
		send_sample(pressed, cur_x, cur_y, tick_now);
	endtask

	// press, a few held samples, release; sometimes stray samples or no release
	task automatic run_gestures(input int n_items);
		int sent;
		int held;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 10) begin
				tick_now = $urandom;
				send_sample(1'($urandom), CW'($urandom), CW'($urandom), tick_now);
				sent++;
			end else begin
				step_and_send(1'b1);
				held = ($urandom_range(9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 4);
				repeat (held) step_and_send(1'b1);
				sent += held + 1;
				if ($urandom_range(9) != 0) begin
					step_and_send(1'b0);
					sent++;
				end
			end
		end
	endtask

	task automatic test_directed_gestures();
		// release while released: nothing happens
		send_sample(1'b0, 16'sd5, -16'sd5, 32'd10);
		// long gap since reset clears taps, then two quick taps
		send_sample(1'b1, 16'sd0, 16'sd0, 32'd1000);
		send_sample(1'b0, 16'sd0, 16'sd0, 32'd1050);
		send_sample(1'b1, 16'sd0, 16'sd0, 32'd1100);
		send_sample(1'b0, 16'sd3, 16'sd0, 32'd1150);
		// corner to corner fling
		send_sample(1'b1, 16'h8000, 16'h8000, 32'd1500);
		send_sample(1'b0, 16'h7FFF, 16'h7FFF, 32'd1800);
		// slow drag: slow steps reach the limit, moves start, count stops one past
		send_sample(1'b1, 16'sd100, 16'sd100, 32'd2000);
		send_sample(1'b1, 16'sd110, 16'sd100, 32'd3000);
		send_sample(1'b1, 16'sd120, 16'sd100, 32'd4000);
		send_sample(1'b1, 16'sd130, 16'sd95, 32'd5000);
		send_sample(1'b1, 16'sd130, 16'sd95, 32'd5100);
		send_sample(1'b1, 16'sd140, 16'sd95, 32'd6000);
		send_sample(1'b0, 16'sd150, 16'sd95, 32'd6100);
		// long press released where it started: up only
		send_sample(1'b1, -16'sd7, 16'sd9, 32'd6200);
		send_sample(1'b0, -16'sd7, 16'sd9, 32'd9000);
		// slow straight press then release: move
		send_sample(1'b1, 16'sd0, 16'sd0, 32'd9100);
		send_sample(1'b0, 16'sd0, 16'sd40, 32'd9700);
		// tick counter wraps while held
		send_sample(1'b1, 16'h7FFF, 16'h8000, 32'hFFFF_FF00);
		send_sample(1'b1, 16'h7FFF, 16'h8000, 32'h0000_0010);
		send_sample(1'b0, 16'h8000, 16'h7FFF, 32'h0000_0080);
		// exactly on the tap gap and click thresholds, then one past
		send_sample(1'b1, 16'sd1, 16'sd1, 32'h0000_01AC);
		send_sample(1'b0, 16'sd1, 16'sd1, 32'h0000_0274);
		send_sample(1'b1, 16'sd1, 16'sd1, 32'h0000_03A1);
		send_sample(1'b0, 16'sd2, 16'sd2, 32'h0000_0468);
		drain_events();
		tick_now = 32'h0000_1000;
	endtask

	task automatic test_config_settings();
		write_all_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_gestures(40);
		drain_events();
		write_all_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_gestures(40);
		drain_events();
		repeat (2) begin
			write_all_config(16'($urandom_range(0, 600)), 16'($urandom_range(0, 800)),
				16'($urandom_range(0, 24)), 16'($urandom_range(0, 6)));
			run_gestures(40);
			drain_events();
		end
		write_all_config(CLICK_MAX_RST, TAP_GAP_RST, FLING_TPP_RST, 16'(SLOW_LIMIT_RST));
	endtask

	// with the limit at 255 the slow count must stick at 255 and keep moves coming
	task automatic test_slow_step_saturation();
		int x;
		write_config(CFG_SLOW_LIMIT, 16'd255);
		x = -140;
		tick_now = 32'd50000;
		send_sample(1'b1, CW'(x), 16'sd0, tick_now);
		repeat (262) begin
			x++;
			tick_now += 1000;
			send_sample(1'b1, CW'(x), 16'sd0, tick_now);
		end
		tick_now += 1000;
		send_sample(1'b0, CW'(x + 3), 16'sd0, tick_now);
		drain_events();
		write_config(CFG_SLOW_LIMIT, 16'(SLOW_LIMIT_RST));
	endtask

	task automatic test_output_backpressure();
		src_calm  = 1'b1;
		sink_hold = 300;
		run_gestures(24);
		src_calm = 1'b0;
		drain_events();
	endtask

	task automatic test_no_idle_stretch();
		src_calm  = 1'b1;
		sink_calm = 1'b1;
		run_gestures(60);
		drain_events();
		src_calm  = 1'b0;
		sink_calm = 1'b0;
	endtask

	task automatic test_random_gestures();
		write_all_config(16'($urandom_range(50, 400)), 16'($urandom_range(100, 600)),
			16'($urandom_range(1, 12)), 16'($urandom_range(1, 5)));
		run_gestures(100);
		drain_events();
	endtask

	initial begin
		arst_n          = 1'b0;
		samp.valid      = 1'b0;
		samp.is_pressed = 1'b0;
		samp.pos_x      = '0;
		samp.pos_y      = '0;
		samp.now_tick   = '0;
		cfg.valid       = 1'b0;
		cfg.index       = CFG_CLICK_MAX;
		cfg.data        = '0;
		src_calm        = 1'b0;
		sink_calm       = 1'b0;
		sink_hold       = 0;
		mismatch_count  = 0;
		held_down       = 1'b0;
		anchor_px       = '0;
		anchor_py       = '0;
		press_tick      = '0;
		tap_run         = '0;
		slow_count      = '0;
		cfg_click_max   = CLICK_MAX_RST;
		cfg_tap_gap     = TAP_GAP_RST;
		cfg_fling_tpp   = FLING_TPP_RST;
		cfg_slow_limit  = SLOW_LIMIT_RST;
		cur_x           = '0;
		cur_y           = '0;
		tick_now        = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_gestures();
		test_config_settings();
		test_slow_step_saturation();
		test_output_backpressure();
		test_no_idle_stretch();
		test_random_gestures();

		if (pending_events.size() != 0)
			$display("%0d expected gesture events never arrived", pending_events.size());
		if (mismatch_count == 0 && pending_events.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[files.f]
rtl/pgr_pkg.sv
rtl/pgr_sample_if.sv
rtl/pgr_event_if.sv
rtl/pgr_cfg_if.sv
rtl/pgr_front.sv
rtl/pgr_queue.sv
rtl/pgr_back.sv
rtl/pointer_gesture_recognizer_core.sv
tb/tb_pointer_gesture_recognizer_core.sv
